@@ hdl/one_shot_tick_timer_bank_top_macros.svh @@
// assertion macros for the one-shot tick timer bank
// expects clk and arst_n in the scope where a macro is used
`ifndef ONE_SHOT_TICK_TIMER_BANK_TOP_MACROS_SVH
`define ONE_SHOT_TICK_TIMER_BANK_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OSTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define OSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ostb_pkg.sv @@
// shared types and constants of the one-shot tick timer bank
// no dependencies
`timescale 1ns / 1ps

package ostb_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int TIMER_W = 32;
	localparam int TAG_W = 32;
	localparam int LED_W = 8;
	localparam int SLOT_OUT_W = 3;
	localparam logic [LED_W-1:0] LED_PERIOD_RST = 8'd25;

	localparam logic FUNC_REGISTER = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_FIRED    = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef struct packed {
		logic             func;
		logic [TIMER_W-1:0] delay_ticks;
		logic [TAG_W-1:0]   owner_tag;
	} cmd_t;

	typedef struct packed {
		kind_t                 kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [TAG_W-1:0]      fired_tag;
		logic                  led_lit;
		logic                  last;
	} res_t;

	// one timer entry as held in the slot ram
	typedef struct packed {
		logic [TIMER_W-1:0] remaining;
		logic [TAG_W-1:0]   owner;
	} entry_t;

endpackage

@@ hdl/one_shot_tick_timer_bank_top.sv @@
// a register transaction answers in the cycle after it is taken, busy stays low
// a tick holds busy through the walk, one ram read per slot, and the done state
// fired results come out at most one per cycle during the walk, done comes last
// one register per cycle while idle; a new tick waits for the walk and done state to end
// reset: arst_n clears busy flags, tick counter, led and strobe; led_period returns to 25
// the slot ram is not cleared, entries are only used for busy slots; receiver cannot stall
`timescale 1ns / 1ps

module one_shot_tick_timer_bank_top import ostb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             strobe,
	output res_t             result,
	input  logic             cfg_wr_en,
	input  logic [LED_W-1:0] cfg_wr_data
);

	`include "one_shot_tick_timer_bank_top_macros.svh"

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W = SLOT_W + 1;
	localparam logic [IDX_W-1:0] NUM_IDX = IDX_W'(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// scan control: next slot to read, and the slot whose data arrives this cycle
	logic [IDX_W-1:0]  scan_idx_q;
	logic              rd_valid_s1;
	logic [SLOT_W-1:0] rd_slot_s1;

	logic [NUM_SLOTS-1:0] slot_busy_q;
	logic [LED_W-1:0]     tick_q;
	logic                 led_q;
	logic [LED_W-1:0]     period_q;
	logic                 strobe_q;
	res_t                 result_q;
	res_t                 res_d;

	// allocator
	logic              alloc_found;
	logic [SLOT_W-1:0] alloc_slot;

	// ram ports
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata_raw;
	entry_t            ram_rdata;

	// decoded transaction and scan events
	logic             accept;
	logic             reg_acc;
	logic             tick_acc;
	logic             scan_more;
	logic             proc_s1;
	logic             dec_s1;
	logic             fire_s1;
	logic             scan_end;
	logic [LED_W-1:0] tick_next;
	logic             hb_wrap;

	ostb_alloc #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_alloc (
		.slot_busy(slot_busy_q),
		.found    (alloc_found),
		.slot     (alloc_slot)
	);

	ostb_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	assign accept = start && (state_q == ST_IDLE);
	assign reg_acc = accept && (cmd.func == FUNC_REGISTER);
	assign tick_acc = accept && (cmd.func == FUNC_TICK);
	assign scan_more = (state_q == ST_SCAN) && (scan_idx_q < NUM_IDX);

	// only busy slots are touched, a free slot's ram word is ignored
	assign proc_s1 = rd_valid_s1 && slot_busy_q[rd_slot_s1];
	assign dec_s1 = proc_s1 && (ram_rdata.remaining != '0);
	assign fire_s1 = proc_s1 && (ram_rdata.remaining == '0);
	assign scan_end = rd_valid_s1 && (rd_slot_s1 == LAST_IDX[SLOT_W-1:0]);

	// heartbeat: wraps at or above the period, 8-bit counter
	assign tick_next = tick_q + LED_W'(1);
	assign hb_wrap = (tick_next >= period_q);

	// ram access steering
	// the walk reads slot k while writing back slot k-1, so the same entry is
	// never read and written in one cycle; registration never overlaps a walk
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = alloc_slot;
		ram_wdata.remaining = cmd.delay_ticks;
		ram_wdata.owner = cmd.owner_tag;
		ram_re = 1'b0;
		ram_raddr = '0;
		if (reg_acc && alloc_found) begin
			ram_we = 1'b1;
		end
		if (dec_s1) begin
			ram_we = 1'b1;
			ram_waddr = rd_slot_s1;
			ram_wdata.remaining = ram_rdata.remaining - TIMER_W'(1);
			ram_wdata.owner = ram_rdata.owner;
		end
		if (tick_acc) begin
			ram_re = 1'b1;
		end else if (scan_more) begin
			ram_re = 1'b1;
			ram_raddr = scan_idx_q[SLOT_W-1:0];
		end
	end

	// result payload for this cycle's transaction
	always_comb begin
		res_d.kind = KIND_DONE;
		res_d.slot = '0;
		res_d.fired_tag = '0;
		res_d.led_lit = led_q;
		res_d.last = 1'b1;
		if (reg_acc) begin
			res_d.kind = alloc_found ? KIND_ACCEPTED : KIND_REJECTED;
			res_d.slot = alloc_found ? SLOT_OUT_W'(alloc_slot) : '0;
		end else if (fire_s1) begin
			res_d.kind = KIND_FIRED;
			res_d.slot = SLOT_OUT_W'(rd_slot_s1);
			res_d.fired_tag = ram_rdata.owner;
			res_d.last = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_slot_s1 <= '0;
			slot_busy_q <= '0;
			tick_q <= '0;
			led_q <= 1'b0;
			period_q <= LED_PERIOD_RST;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					rd_valid_s1 <= 1'b0;
					if (reg_acc) begin
						strobe_q <= 1'b1;
						if (alloc_found) begin
							slot_busy_q[alloc_slot] <= 1'b1;
						end
					end else if (tick_acc) begin
						// heartbeat first so every result of this tick sees the new led
						if (hb_wrap) begin
							tick_q <= '0;
							led_q <= ~led_q;
						end else begin
							tick_q <= tick_next;
						end
						rd_valid_s1 <= 1'b1;
						rd_slot_s1 <= '0;
						scan_idx_q <= IDX_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_valid_s1 <= scan_more;
					rd_slot_s1 <= scan_idx_q[SLOT_W-1:0];
					if (scan_more) begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
					if (fire_s1) begin
						slot_busy_q[rd_slot_s1] <= 1'b0;
						strobe_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_valid_s1 <= 1'b0;
					strobe_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					rd_valid_s1 <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// every register transaction is answered in the next cycle
	`OSTB_ASSERT_NEXT(a_reg_answer, reg_acc, strobe && result.last && (result.kind == KIND_ACCEPTED || result.kind == KIND_REJECTED), "register transaction not answered")
	// a fire result only comes out while the walk is still running
	`OSTB_ASSERT_NOW(a_fire_in_walk, strobe && (result.kind == KIND_FIRED), busy && !result.last, "fire result outside of a tick walk")
	// ram data is consumed only during a walk
	`OSTB_ASSERT_NOW(a_rd_in_scan, rd_valid_s1, state_q == ST_SCAN, "slot ram data outside of the walk")
	// a tick always closes with a done result that ends the transaction
	`OSTB_ASSERT_NEXT(a_done_last, state_q == ST_DONE, strobe && result.last && (result.kind == KIND_DONE) && !busy, "tick not closed by done")

endmodule

@@ hdl/ostb_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ostb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/ostb_alloc.sv @@
// lowest free slot finder over the busy flags
// no dependencies
`timescale 1ns / 1ps

module ostb_alloc #(
	parameter int NUM_SLOTS = 8,
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic [NUM_SLOTS-1:0] slot_busy,
	output logic                 found,
	output logic [SLOT_W-1:0]    slot
);

	// walk down so the lowest free slot wins
	always_comb begin
		found = 1'b0;
		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!slot_busy[i]) begin
				found = 1'b1;
				slot = SLOT_W'(i);
			end
		end
	end

endmodule
